// ===== hdl/i2cmbs_pkg.sv =====
package i2cmbs_pkg;

  // command codes held in the sequencer state
  localparam logic [2:0] CMD_IDLE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_WRITE     = 3'd2;
  localparam logic [2:0] CMD_READ      = 3'd3;
  localparam logic [2:0] CMD_STOP      = 3'd4;
  localparam logic [2:0] CMD_STOP_FAIL = 3'd5;

  // phase of a write in which the slave ack is polled
  localparam logic [3:0] POLL_PHASE = 4'd5;

  // bit counter value that ends a byte
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd250;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } in_beat_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       ack_failed;
    logic [7:0] read_value;
  } out_beat_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] phase;
    logic [2:0] tick_count;
    logic [3:0] bit_index;
    logic [7:0] shift_byte;
    logic [7:0] poll_count;
    logic       ack_choice;
  } seq_state_t;

endpackage

// ===== hdl/i2cmbs_step.sv =====
module i2cmbs_step (
  input  i2cmbs_pkg::seq_state_t state_cur,
  input  i2cmbs_pkg::in_beat_t   beat_in,
  input  logic [7:0]             ack_poll_limit,
  output i2cmbs_pkg::seq_state_t state_nxt,
  output i2cmbs_pkg::out_beat_t  beat_out
);

  i2cmbs_pkg::seq_state_t w;
  logic       seg_scl;
  logic       seg_sda;
  logic [2:0] seg_dur;
  logic [3:0] last_phase;
  logic [2:0] tick_inc;
  logic [8:0] poll_inc;
  logic [3:0] phase_new;
  logic [3:0] bit_inc;
  logic       finish;
  logic       ack_bit;

  // timing table of one segment
  always_comb begin
    ack_bit = ~w.ack_choice;
    seg_scl = 1'b1;
    seg_sda = 1'b1;
    seg_dur = 3'd1;
    case (w.cmd)
      i2cmbs_pkg::CMD_START: begin
        case (w.phase)
          4'd0: begin seg_scl = 1'b1; seg_sda = 1'b1; seg_dur = 3'd4; end
          4'd1: begin seg_scl = 1'b1; seg_sda = 1'b0; seg_dur = 3'd4; end
          4'd2: begin seg_scl = 1'b0; seg_sda = 1'b0; seg_dur = 3'd2; end
          default: ;
        endcase
      end
      i2cmbs_pkg::CMD_STOP, i2cmbs_pkg::CMD_STOP_FAIL: begin
        case (w.phase)
          4'd0: begin seg_scl = 1'b0; seg_sda = 1'b0; seg_dur = 3'd4; end
          4'd1: begin seg_scl = 1'b1; seg_sda = 1'b1; seg_dur = 3'd4; end
          4'd2: begin seg_scl = 1'b0; seg_sda = 1'b1; seg_dur = 3'd2; end
          4'd3: begin seg_scl = 1'b1; seg_sda = 1'b1; seg_dur = 3'd2; end
          default: ;
        endcase
      end
      i2cmbs_pkg::CMD_WRITE: begin
        case (w.phase)
          4'd0: begin seg_scl = 1'b0; seg_sda = w.shift_byte[7]; seg_dur = 3'd2; end
          4'd1: begin seg_scl = 1'b1; seg_sda = w.shift_byte[7]; seg_dur = 3'd2; end
          4'd2: begin seg_scl = 1'b0; seg_sda = w.shift_byte[7]; seg_dur = 3'd2; end
          4'd3: begin seg_scl = 1'b0; seg_sda = 1'b1; seg_dur = 3'd1; end
          4'd4: begin seg_scl = 1'b1; seg_sda = 1'b1; seg_dur = 3'd1; end
          default: ;
        endcase
      end
      i2cmbs_pkg::CMD_READ: begin
        case (w.phase)
          4'd0: begin seg_scl = 1'b0; seg_sda = 1'b1; seg_dur = 3'd2; end
          4'd1: begin seg_scl = 1'b1; seg_sda = 1'b1; seg_dur = 3'd1; end
          4'd2: begin seg_scl = 1'b0; seg_sda = ack_bit; seg_dur = 3'd2; end
          4'd3: begin seg_scl = 1'b1; seg_sda = ack_bit; seg_dur = 3'd2; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    case (w.cmd)
      i2cmbs_pkg::CMD_START: last_phase = 4'd2;
      i2cmbs_pkg::CMD_WRITE: last_phase = i2cmbs_pkg::POLL_PHASE;
      default:               last_phase = 4'd3;
    endcase
  end

  always_comb begin
    // command launch, only from idle
    w = state_cur;
    if (state_cur.cmd == i2cmbs_pkg::CMD_IDLE && beat_in.mode inside {[3'd1:3'd4]}) begin
      w.cmd        = beat_in.mode;
      w.phase      = 4'd0;
      w.tick_count = 3'd0;
      w.bit_index  = 4'd0;
      w.shift_byte = (beat_in.mode == i2cmbs_pkg::CMD_WRITE) ? beat_in.data_byte : 8'd0;
      w.poll_count = 8'd0;
      w.ack_choice = (beat_in.mode == i2cmbs_pkg::CMD_READ) ? beat_in.send_ack : 1'b0;
    end

    state_nxt = w;
    beat_out  = '0;
    finish    = 1'b0;
    tick_inc  = w.tick_count + 3'd1;
    poll_inc  = {1'b0, w.poll_count} + 9'd1;
    bit_inc   = w.bit_index + 4'd1;
    phase_new = w.phase + 4'd1;

    if (w.cmd == i2cmbs_pkg::CMD_IDLE) begin
      beat_out.scl_level = ~w.phase[0];
      beat_out.sda_level = ~w.phase[1];
    end else if (w.cmd == i2cmbs_pkg::CMD_WRITE && w.phase == i2cmbs_pkg::POLL_PHASE) begin
      beat_out.busy_res  = 1'b1;
      beat_out.scl_level = 1'b1;
      beat_out.sda_level = 1'b1;
      if (!beat_in.sda_in) begin
        finish = 1'b1;
      end else if (poll_inc > {1'b0, ack_poll_limit}) begin
        state_nxt.cmd        = i2cmbs_pkg::CMD_STOP_FAIL;
        state_nxt.phase      = 4'd0;
        state_nxt.tick_count = 3'd0;
        state_nxt.poll_count = 8'd0;
      end else begin
        state_nxt.poll_count = poll_inc[7:0];
      end
    end else begin
      beat_out.busy_res  = 1'b1;
      beat_out.scl_level = seg_scl;
      beat_out.sda_level = seg_sda;
      // read samples sda on the first high tick
      if (w.cmd == i2cmbs_pkg::CMD_READ && w.phase == 4'd1 && w.tick_count == 3'd0) begin
        state_nxt.shift_byte = {w.shift_byte[6:0], beat_in.sda_in};
      end
      state_nxt.tick_count = tick_inc;
      if (tick_inc >= seg_dur) begin
        state_nxt.tick_count = 3'd0;
        if (w.cmd == i2cmbs_pkg::CMD_WRITE && w.phase == 4'd2) begin
          state_nxt.shift_byte = {w.shift_byte[6:0], 1'b0};
          state_nxt.bit_index  = bit_inc;
          phase_new = (bit_inc < i2cmbs_pkg::BITS_PER_BYTE) ? 4'd0 : 4'd3;
        end else if (w.cmd == i2cmbs_pkg::CMD_READ && w.phase == 4'd1) begin
          state_nxt.bit_index = bit_inc;
          phase_new = (bit_inc < i2cmbs_pkg::BITS_PER_BYTE) ? 4'd0 : 4'd2;
        end
        state_nxt.phase = phase_new;
        if (phase_new > last_phase) begin
          finish = 1'b1;
        end
      end
    end

    if (finish) begin
      beat_out.done_res   = 1'b1;
      beat_out.ack_failed = (w.cmd == i2cmbs_pkg::CMD_STOP_FAIL);
      beat_out.read_value = (w.cmd == i2cmbs_pkg::CMD_READ) ? state_nxt.shift_byte : 8'd0;
      // resting levels: bit 0 scl low, bit 1 sda low
      if (w.cmd == i2cmbs_pkg::CMD_START) begin
        state_nxt.phase = 4'd3;
      end else if (w.cmd == i2cmbs_pkg::CMD_READ && w.ack_choice) begin
        state_nxt.phase = 4'd3;
      end else begin
        state_nxt.phase = 4'd1;
      end
      state_nxt.cmd        = i2cmbs_pkg::CMD_IDLE;
      state_nxt.tick_count = 3'd0;
      state_nxt.bit_index  = 4'd0;
    end
  end

endmodule

// ===== hdl/i2cmbs_obuf.sv =====
module i2cmbs_obuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  input  i2cmbs_pkg::out_beat_t push_data,
  output logic                  push_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cmbs_pkg::out_beat_t out_data
);

  logic                  main_valid_r;
  logic                  skid_valid_r;
  i2cmbs_pkg::out_beat_t main_r;
  i2cmbs_pkg::out_beat_t skid_r;
  logic                  pop;
  logic                  push;

  assign push_ready = ~skid_valid_r;
  assign out_valid  = main_valid_r;
  assign out_data   = main_r;
  assign pop        = main_valid_r & out_ready;
  assign push       = push_valid & push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!main_valid_r || pop) begin
      main_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (!main_valid_r || pop) begin
      if (push) begin
        main_r <= push_data;
      end
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

// ===== hdl/i2c_master_bit_sequencer.sv =====
// channel   | direction | ports                         | beat
// ----------+-----------+-------------------------------+---------------------------------
// in        | in        | in_valid, in_ready, in_data   | one bus tick, optional command
// out       | out       | out_valid, out_ready, out_data| scl/sda levels and status of it
// cfg       | in        | cfg_we, cfg_wdata             | ack poll limit, written at once
//
// one tick per clock while in_ready is high: each accepted beat updates the sequencer
// state and its result is registered in the output buffer, one beat in, one beat out
// the per-tick path is the segment table, tick compare and poll compare
// synchronous active-low reset: bus lines released, idle, poll limit 250
// a two-entry output buffer takes a tick while the previous result is stalled;
// input stalls only when both entries are full
module i2c_master_bit_sequencer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cmbs_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cmbs_pkg::out_beat_t out_data,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata
);

  // sequencer state, advanced once per accepted tick
  i2cmbs_pkg::seq_state_t state_r;
  i2cmbs_pkg::seq_state_t state_nxt;
  logic [7:0]             poll_limit_r;
  i2cmbs_pkg::out_beat_t  step_beat;
  logic                   accept;

  assign accept = in_valid & in_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= i2cmbs_pkg::ACK_POLL_LIMIT_RST;
    end else if (cfg_we) begin
      poll_limit_r <= cfg_wdata;
    end
  end

  // state only moves on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // next state and this tick's bus levels
  i2cmbs_step u_step (
    .state_cur      (state_r),
    .beat_in        (in_data),
    .ack_poll_limit (poll_limit_r),
    .state_nxt      (state_nxt),
    .beat_out       (step_beat)
  );

  // result register plus skid entry
  i2cmbs_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_data  (step_beat),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
